// File: design/hdlc_rx_pkg.sv
// Shared types, codes and limits for the HDLC-style frame receiver.
// Depends on nothing; imported by hdlc_style_frame_receiver.
`default_nettype none

package hdlc_rx_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned CFG_AW      = 5;

  // Channel payload widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 1;

  // Byte count at which a further payload byte overflows (payload plus trailer)
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD + 1);

  // Input kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_FLAG     = 3'd0;
  localparam logic [2:0] REG_ESCAPE   = 3'd1;
  localparam logic [2:0] REG_ESC_FLAG = 3'd2;
  localparam logic [2:0] REG_ESC_ESC  = 3'd3;
  localparam logic [2:0] REG_ADDRESS  = 3'd4;
  localparam logic [2:0] REG_EXP_CTRL = 3'd5;
  localparam logic [2:0] REG_DUP_CTRL = 3'd6;

  // Reported state codes
  localparam logic [3:0] CODE_START  = 4'd0;
  localparam logic [3:0] CODE_FLAG   = 4'd1;
  localparam logic [3:0] CODE_ADDR   = 4'd2;
  localparam logic [3:0] CODE_CTRL   = 4'd3;
  localparam logic [3:0] CODE_HDR    = 4'd4;
  localparam logic [3:0] CODE_DATA   = 4'd5;
  localparam logic [3:0] CODE_ESC    = 4'd6;
  localparam logic [3:0] CODE_STOP   = 4'd7;
  localparam logic [3:0] CODE_DUP    = 4'd8;
  localparam logic [3:0] CODE_REJECT = 4'd9;

  // Frame events
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_GOOD     = 3'd1;
  localparam logic [2:0] EV_BAD_FCS  = 3'd2;
  localparam logic [2:0] EV_DUP      = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;

  typedef enum logic [9:0] {
    S_START  = 10'b00_0000_0001,
    S_FLAG   = 10'b00_0000_0010,
    S_ADDR   = 10'b00_0000_0100,
    S_CTRL   = 10'b00_0000_1000,
    S_HDR    = 10'b00_0001_0000,
    S_DATA   = 10'b00_0010_0000,
    S_ESC    = 10'b00_0100_0000,
    S_STOP   = 10'b00_1000_0000,
    S_DUP    = 10'b01_0000_0000,
    S_REJECT = 10'b10_0000_0000
  } rx_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] frame_length;
    logic [2:0]       event_res;
    logic [7:0]       data_byte;
    logic [3:0]       state_code;
  } result_t;

  function automatic logic [3:0] state_to_code(input rx_state_t s);
    logic [3:0] code;
    case (s)
      S_START:  code = CODE_START;
      S_FLAG:   code = CODE_FLAG;
      S_ADDR:   code = CODE_ADDR;
      S_CTRL:   code = CODE_CTRL;
      S_HDR:    code = CODE_HDR;
      S_DATA:   code = CODE_DATA;
      S_ESC:    code = CODE_ESC;
      S_STOP:   code = CODE_STOP;
      S_DUP:    code = CODE_DUP;
      S_REJECT: code = CODE_REJECT;
      default:  code = CODE_START;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: design/hdlc_style_frame_receiver.sv
// HDLC-style byte-stuffed frame receiver: header check, destuffing, trailer XOR check.
// Depends on hdlc_rx_pkg (types, codes, limits).
//
//   channel    | dir | handshake                 | payload
//   -----------+-----+---------------------------+------------------------------------------
//   s_axis     | in  | tvalid/tready             | tdata: rx_byte; tuser: kind
//   m_axis     | out | tvalid/tready             | tdata: state_code, data_byte, event_res,
//              |     |                           |        frame_length; tuser: data_valid
//   apb config | in  | psel/penable/pwrite/pready| 7 byte registers at 4*index
//
// The receiver state is updated at the edge a line byte is accepted, and its result is
// registered at that edge, into the output register when it is free or else into the
// skid register, so one result leaves per cycle while the sink keeps tready high. A
// one-entry skid register behind the output register keeps s_axis_tready a flop output;
// while it is full the input stalls. Reset (synchronous) returns the receiver to its
// start state, empties both output stages and loads the register defaults.
`default_nettype none

module hdlc_style_frame_receiver (
  input  wire                                  clk,
  input  wire                                  rst,
  // Line byte stream
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [hdlc_rx_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  wire  [hdlc_rx_pkg::IN_USER_W-1:0]    s_axis_tuser,   // [0] kind
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [3:0] state_code, [11:4] data_byte, [14:12] event_res, [25:15] frame_length,
  // [31:26] zero
  output logic [hdlc_rx_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [hdlc_rx_pkg::OUT_USER_W-1:0]   m_axis_tuser,   // [0] data_valid
  // Configuration
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [hdlc_rx_pkg::CFG_AW-1:0]       paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import hdlc_rx_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] flag_byte;
  logic [7:0] escape_byte;
  logic [7:0] escaped_flag_code;
  logic [7:0] escaped_escape_code;
  logic [7:0] address_byte;
  logic [7:0] expected_ctrl;
  logic [7:0] duplicate_ctrl;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte           <= 8'd126;
      escape_byte         <= 8'd125;
      escaped_flag_code   <= 8'd94;
      escaped_escape_code <= 8'd93;
      address_byte        <= 8'd3;
      expected_ctrl       <= 8'd0;
      duplicate_ctrl      <= 8'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FLAG:     flag_byte           <= pwdata[7:0];
        REG_ESCAPE:   escape_byte         <= pwdata[7:0];
        REG_ESC_FLAG: escaped_flag_code   <= pwdata[7:0];
        REG_ESC_ESC:  escaped_escape_code <= pwdata[7:0];
        REG_ADDRESS:  address_byte        <= pwdata[7:0];
        REG_EXP_CTRL: expected_ctrl       <= pwdata[7:0];
        REG_DUP_CTRL: duplicate_ctrl      <= pwdata[7:0];
        default: ;  // write beyond the register list: drop
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_FLAG:     prdata = {24'd0, flag_byte};
      REG_ESCAPE:   prdata = {24'd0, escape_byte};
      REG_ESC_FLAG: prdata = {24'd0, escaped_flag_code};
      REG_ESC_ESC:  prdata = {24'd0, escaped_escape_code};
      REG_ADDRESS:  prdata = {24'd0, address_byte};
      REG_EXP_CTRL: prdata = {24'd0, expected_ctrl};
      REG_DUP_CTRL: prdata = {24'd0, duplicate_ctrl};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Receiver state
  // ---------------------------------------------------------------------------
  rx_state_t        rx_state, rx_state_next;
  logic [7:0]       running_check, running_check_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic [7:0]       address_seen, address_seen_next;
  logic [7:0]       control_seen, control_seen_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;

  logic             in_accept;
  logic             kind;
  logic [7:0]       rx_byte;

  // Per-transaction result
  logic             res_valid;
  logic [7:0]       res_byte;
  logic [2:0]       res_event;
  result_t          res_data;

  // Destuffed byte handed to the payload path
  logic             take;
  logic [7:0]       take_value;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign kind      = s_axis_tuser[0];
  assign rx_byte   = s_axis_tdata;

  always_comb begin
    rx_state_next      = rx_state;
    running_check_next = running_check;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    address_seen_next  = address_seen;
    control_seen_next  = control_seen;
    byte_count_next    = byte_count;
    res_valid          = 1'b0;
    res_byte           = 8'd0;
    res_event          = EV_NONE;
    take               = 1'b0;
    take_value         = 8'd0;

    if (kind == KIND_RESTART) begin
      // Restart: back to the start state with a clean frame
      rx_state_next      = S_START;
      address_seen_next  = 8'd0;
      control_seen_next  = 8'd0;
      running_check_next = 8'd0;
      held_byte_next     = 8'd0;
      held_valid_next    = 1'b0;
      byte_count_next    = '0;
    end else begin
      case (rx_state)
        S_FLAG: begin
          if (rx_byte == address_byte) begin
            address_seen_next = rx_byte;
            rx_state_next     = S_ADDR;
          end else if (rx_byte == flag_byte) begin
            rx_state_next = S_FLAG;
          end else begin
            rx_state_next = S_START;
          end
        end
        S_ADDR: begin
          if (rx_byte == expected_ctrl) begin
            control_seen_next = rx_byte;
            rx_state_next     = S_CTRL;
          end else if (rx_byte == duplicate_ctrl) begin
            rx_state_next = S_DUP;
            res_event     = EV_DUP;
          end else if (rx_byte == flag_byte) begin
            rx_state_next = S_FLAG;
          end else begin
            rx_state_next = S_START;
          end
        end
        S_CTRL: begin
          if (rx_byte == (address_seen ^ control_seen)) begin
            // Header good: open a fresh payload
            running_check_next = 8'd0;
            held_byte_next     = 8'd0;
            held_valid_next    = 1'b0;
            byte_count_next    = '0;
            rx_state_next      = S_HDR;
          end else if (rx_byte == flag_byte) begin
            rx_state_next = S_FLAG;
          end else begin
            rx_state_next = S_START;
          end
        end
        S_HDR, S_DATA: begin
          // Escape wins over flag when both registers hold the same value
          if (rx_byte == escape_byte) begin
            rx_state_next = S_ESC;
          end else if (rx_byte == flag_byte) begin
            if (byte_count < CNT_W'(2)) begin
              byte_count_next = '0;
              rx_state_next   = S_REJECT;
              res_event       = EV_BAD_FCS;
            end else begin
              byte_count_next = byte_count - CNT_W'(1);
              if (running_check == 8'd0) begin
                rx_state_next = S_STOP;
                res_event     = EV_GOOD;
              end else begin
                rx_state_next = S_REJECT;
                res_event     = EV_BAD_FCS;
              end
            end
            held_valid_next    = 1'b0;
            running_check_next = 8'd0;
          end else begin
            take       = 1'b1;
            take_value = rx_byte;
          end
        end
        S_ESC: begin
          take = 1'b1;
          if (rx_byte == escaped_flag_code) begin
            take_value = flag_byte;
          end else if (rx_byte == escaped_escape_code) begin
            take_value = escape_byte;
          end else begin
            take_value = 8'd0;  // unknown escape code stands for a zero byte
          end
        end
        S_STOP: begin
          // Hold until restart
        end
        default: begin
          // Start, duplicate and reject all hunt for an opening flag
          byte_count_next = '0;
          held_valid_next = 1'b0;
          rx_state_next   = (rx_byte == flag_byte) ? S_FLAG : S_START;
        end
      endcase

      if (take) begin
        if (byte_count >= CNT_LIMIT) begin
          // Overflow: drop the held byte and reject the frame
          if (held_valid && (byte_count != '0)) begin
            byte_count_next = byte_count - CNT_W'(1);
          end
          held_valid_next = 1'b0;
          rx_state_next   = S_REJECT;
          res_event       = EV_OVERFLOW;
        end else begin
          // Release the previous byte, hold the new one back as a trailer candidate
          if (held_valid) begin
            res_valid = 1'b1;
            res_byte  = held_byte;
          end
          held_byte_next     = take_value;
          held_valid_next    = 1'b1;
          running_check_next = running_check ^ take_value;
          byte_count_next    = byte_count + CNT_W'(1);
          rx_state_next      = S_DATA;
        end
      end
    end

    res_data.state_code   = state_to_code(rx_state_next);
    res_data.data_byte    = res_byte;
    res_data.event_res    = res_event;
    res_data.frame_length = byte_count_next - CNT_W'(held_valid_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_state      <= S_START;
      running_check <= 8'd0;
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      address_seen  <= 8'd0;
      control_seen  <= 8'd0;
      byte_count    <= '0;
    end else if (in_accept) begin
      rx_state      <= rx_state_next;
      running_check <= running_check_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      address_seen  <= address_seen_next;
      control_seen  <= control_seen_next;
      byte_count    <= byte_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------------
  logic    out_valid;
  logic    out_dv;
  result_t out_data;
  logic    skid_valid;
  logic    skid_dv;
  result_t skid_data;

  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      // Output stage free: refill from the skid first, else from the new transaction
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_dv   <= skid_dv;
      end else if (in_accept) begin
        out_data <= res_data;
        out_dv   <= res_valid;
      end
    end else if (in_accept) begin
      skid_data <= res_data;
      skid_dv   <= res_valid;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_data};
  assign m_axis_tuser  = out_dv;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output stage empty");

  a_held_only_in_payload: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (rx_state == S_DATA || rx_state == S_ESC))
    else $error("held byte outside payload states");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_LIMIT)
    else $error("byte count beyond payload limit");

  a_payload_in_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (out_data.state_code == CODE_DATA &&
                                            out_data.event_res == EV_NONE))
    else $error("payload byte released outside data state");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !skid_valid))
    else $error("output stages not empty after reset");

endmodule

`default_nettype wire

// File: verif/hdlc_style_frame_receiver_test.sv
// Self-checking testbench for hdlc_style_frame_receiver: drives byte-stuffed frames and noise,
// predicts every result with a local deframer and compares it with the output stream.
// Depends on hdlc_rx_pkg and hdlc_style_frame_receiver.

module hdlc_style_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlc_rx_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;    // output register plus skid stage, with margin
  localparam int RANDOM_ITEMS = 120;  // random line items per configuration phase

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } line_item_t;

  typedef struct packed {
    logic [3:0]       state_code;
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [2:0]       event_res;
    logic [CNT_W-1:0] frame_length;
  } rx_result_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE} ready_mode_t;
  typedef enum logic [1:0] {FR_GOOD, FR_BAD_TRAILER, FR_DUP, FR_BAD_HEADER} frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;      // [7:0] rx_byte
  logic [0:0]  s_axis_tuser = '0;      // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [3:0] state, [11:4] byte, [14:12] event, [25:15] length
  logic [0:0]  m_axis_tuser;           // [0] data_valid
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hdlc_style_frame_receiver uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Line items waiting to be offered, and results the deframer copy says must come out.
  line_item_t line_q[$];
  rx_result_t frame_out_q[$];
  int         queued_total = 0;
  int         err_count = 0;
  int         result_idx = 0;

  // Deframer copy: register values and per-frame state.
  logic [7:0]  cfg [0:6];
  logic [3:0]  rx_code;
  logic [7:0]  xor_acc;
  logic [7:0]  held_byte;
  logic        held_ok;
  logic [7:0]  addr_seen;
  logic [7:0]  ctrl_seen;
  int unsigned pay_count;

  // Sender burst shaping and receiver stall pattern.
  int          burst_left = 0;
  int          gap_left = 0;
  ready_mode_t rdy_mode = RDY_ALWAYS;
  int          mode_left = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               result_idx, what, got, want);
  endtask

  // Accept one destuffed byte into the frame; the previously held byte goes out, or on overflow the frame is rejected.
  function automatic void take_payload(input logic [7:0] b, inout rx_result_t r);
    if (pay_count >= MAX_PAYLOAD + 1) begin
      // Overflow: drop the held byte, reject the frame
      if (held_ok && pay_count > 0) pay_count--;
      held_ok = 1'b0;
      rx_code = CODE_REJECT;
      r.event_res = EV_OVERFLOW;
    end else begin
      if (held_ok) begin
        r.data_valid = 1'b1;
        r.data_byte = held_byte;
      end
      held_byte = b;
      held_ok = 1'b1;
      xor_acc ^= b;
      pay_count++;
      rx_code = CODE_DATA;
    end
  endfunction

  // Advance the deframer copy by one line item and return the result it must produce.
  function automatic rx_result_t deframe_step(input logic kind, input logic [7:0] b);
    rx_result_t r;
    r = '0;
    if (kind == KIND_RESTART) begin
      rx_code = CODE_START;
      addr_seen = '0;
      ctrl_seen = '0;
      xor_acc = '0;
      held_byte = '0;
      held_ok = 1'b0;
      pay_count = 0;
    end else begin
      case (rx_code)
        CODE_FLAG: begin
          if (b == cfg[REG_ADDRESS]) begin
            addr_seen = b;
            rx_code = CODE_ADDR;
          end else if (b == cfg[REG_FLAG]) rx_code = CODE_FLAG;
          else rx_code = CODE_START;
        end
        CODE_ADDR: begin
          // expected control wins over duplicate, duplicate over flag
          if (b == cfg[REG_EXP_CTRL]) begin
            ctrl_seen = b;
            rx_code = CODE_CTRL;
          end else if (b == cfg[REG_DUP_CTRL]) begin
            rx_code = CODE_DUP;
            r.event_res = EV_DUP;
          end else if (b == cfg[REG_FLAG]) rx_code = CODE_FLAG;
          else rx_code = CODE_START;
        end
        CODE_CTRL: begin
          if (b == (addr_seen ^ ctrl_seen)) begin
            xor_acc = '0;
            held_byte = '0;
            held_ok = 1'b0;
            pay_count = 0;
            rx_code = CODE_HDR;
          end else if (b == cfg[REG_FLAG]) rx_code = CODE_FLAG;
          else rx_code = CODE_START;
        end
        CODE_HDR, CODE_DATA: begin
          // escape is tested before flag
          if (b == cfg[REG_ESCAPE]) rx_code = CODE_ESC;
          else if (b == cfg[REG_FLAG]) begin
            if (pay_count < 2) begin
              pay_count = 0;
              rx_code = CODE_REJECT;
              r.event_res = EV_BAD_FCS;
            end else begin
              pay_count--;
              if (xor_acc == 8'd0) begin
                rx_code = CODE_STOP;
                r.event_res = EV_GOOD;
              end else begin
                rx_code = CODE_REJECT;
                r.event_res = EV_BAD_FCS;
              end
            end
            held_ok = 1'b0;
            xor_acc = '0;
          end else take_payload(b, r);
        end
        CODE_ESC: begin
          // unknown escape code stands for a zero byte
          if (b == cfg[REG_ESC_FLAG]) take_payload(cfg[REG_FLAG], r);
          else if (b == cfg[REG_ESC_ESC]) take_payload(cfg[REG_ESCAPE], r);
          else take_payload(8'h00, r);
        end
        CODE_STOP: begin
          // sticky until a restart
        end
        default: begin
          // start, duplicate and reject all look for a flag
          pay_count = 0;
          held_ok = 1'b0;
          rx_code = (b == cfg[REG_FLAG]) ? CODE_FLAG : CODE_START;
        end
      endcase
    end
    r.state_code = rx_code;
    r.frame_length = CNT_W'(pay_count - (held_ok ? 1 : 0));
    return r;
  endfunction

  // Sender: offer the head of line_q in bursts, hold it until accepted, predict on acceptance.
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg[REG_FLAG] = 8'd126;
      cfg[REG_ESCAPE] = 8'd125;
      cfg[REG_ESC_FLAG] = 8'd94;
      cfg[REG_ESC_ESC] = 8'd93;
      cfg[REG_ADDRESS] = 8'd3;
      cfg[REG_EXP_CTRL] = 8'd0;
      cfg[REG_DUP_CTRL] = 8'd64;
      rx_code = CODE_START;
      addr_seen = '0;
      ctrl_seen = '0;
      xor_acc = '0;
      held_byte = '0;
      held_ok = 1'b0;
      pay_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_out_q.push_back(deframe_step(s_axis_tuser[0], s_axis_tdata));
        void'(line_q.pop_front());
      end
      // hold an offered item that was not taken
      nv = s_axis_tvalid && !s_axis_tready;
      if (!nv && line_q.size() > 0) begin
        if (gap_left > 0) gap_left--;
        else begin
          nv = 1'b1;
          if (burst_left > 1) burst_left--;
          else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
      s_axis_tvalid <= nv;
      if (nv) begin
        s_axis_tdata <= line_q[0].rx_byte;
        s_axis_tuser <= line_q[0].kind;
      end
    end
  end

  // Receiver stall pattern: alternating stretches of always-ready, random and sparse ready,
  // plus one long hold-off once armed so the block backs up into its input.
  always @(posedge clk) begin
    logic nr;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_armed && !hold_done) begin
        if (hold_count < HOLD_CYCLES) begin
          hold_count++;
          nr = 1'b0;
        end else begin
          hold_done = 1'b1;
          nr = 1'b1;
        end
      end else begin
        if (mode_left == 0) begin
          rdy_mode = ready_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(4, 40);
        end else mode_left--;
        case (rdy_mode)
          RDY_ALWAYS: nr = 1'b1;
          RDY_RANDOM: nr = 1'($urandom_range(0, 1));
          default:    nr = ($urandom_range(0, 3) == 0);
        endcase
      end
      m_axis_tready <= nr;
    end
  end

  // Result checker: every accepted result against the oldest prediction, field by field.
  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frame_out_q.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, '0);
      end else begin
        want = frame_out_q.pop_front();
        if (m_axis_tdata[3:0] != want.state_code)
          report_mismatch("state_code", 32'(m_axis_tdata[3:0]), 32'(want.state_code));
        if (m_axis_tuser[0] != want.data_valid)
          report_mismatch("data_valid", 32'(m_axis_tuser[0]), 32'(want.data_valid));
        if (m_axis_tdata[11:4] != want.data_byte)
          report_mismatch("data_byte", 32'(m_axis_tdata[11:4]), 32'(want.data_byte));
        if (m_axis_tdata[14:12] != want.event_res)
          report_mismatch("event_res", 32'(m_axis_tdata[14:12]), 32'(want.event_res));
        if (m_axis_tdata[25:15] != want.frame_length)
          report_mismatch("frame_length", 32'(m_axis_tdata[25:15]),
                          32'(want.frame_length));
        if (m_axis_tdata[31:26] != '0)
          report_mismatch("tdata padding", 32'(m_axis_tdata[31:26]), '0);
      end
      result_idx++;
    end
  end

  task automatic push_line(input logic kind, input logic [7:0] b);
    line_q.push_back('{kind: kind, rx_byte: b});
    queued_total++;
  endtask

  // Stuff one payload byte the way a transmitter would.
  task automatic push_stuffed(input logic [7:0] b);
    if (b == cfg[REG_ESCAPE]) begin
      push_line(KIND_BYTE, cfg[REG_ESCAPE]);
      push_line(KIND_BYTE, cfg[REG_ESC_ESC]);
    end else if (b == cfg[REG_FLAG]) begin
      push_line(KIND_BYTE, cfg[REG_ESCAPE]);
      push_line(KIND_BYTE, cfg[REG_ESC_FLAG]);
    end else push_line(KIND_BYTE, b);
  endtask

  // Queue one frame built from the current register values.
  task automatic queue_frame(input frame_kind_t fk, input int n_pay, input bit restart);
    logic [7:0] ctrl;
    logic [7:0] hdr;
    logic [7:0] chk;
    logic [7:0] b;
    if (restart) push_line(KIND_RESTART, 8'($urandom_range(0, 255)));
    push_line(KIND_BYTE, cfg[REG_FLAG]);
    if ($urandom_range(0, 4) == 0) push_line(KIND_BYTE, cfg[REG_FLAG]);
    push_line(KIND_BYTE, cfg[REG_ADDRESS]);
    ctrl = (fk == FR_DUP) ? cfg[REG_DUP_CTRL] : cfg[REG_EXP_CTRL];
    push_line(KIND_BYTE, ctrl);
    if (fk != FR_DUP) begin
      hdr = cfg[REG_ADDRESS] ^ ctrl;
      if (fk == FR_BAD_HEADER) hdr ^= 8'($urandom_range(1, 255));
      push_line(KIND_BYTE, hdr);
      chk = '0;
      for (int i = 0; i < n_pay; i++) begin
        // lean on the special byte values now and then
        case ($urandom_range(0, 7))
          0: b = cfg[REG_FLAG];
          1: b = cfg[REG_ESCAPE];
          default: b = 8'($urandom_range(0, 255));
        endcase
        chk ^= b;
        push_stuffed(b);
      end
      if (fk == FR_BAD_TRAILER) chk ^= 8'($urandom_range(1, 255));
      push_stuffed(chk);
      push_line(KIND_BYTE, cfg[REG_FLAG]);
    end
  endtask

  // Mostly well-formed frames with random content; the rest broken frames and line noise.
  task automatic queue_random(input int n_items);
    int start;
    int pick;
    int n;
    logic [7:0] b;
    start = queued_total;
    while (queued_total - start < n_items) begin
      pick = $urandom_range(0, 19);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case (pick)
        0, 1: begin
          for (int i = $urandom_range(3, 12); i > 0; i--) begin
            case ($urandom_range(0, 5))
              0: b = cfg[REG_FLAG];
              1: b = cfg[REG_ESCAPE];
              2: b = cfg[REG_ADDRESS];
              3: b = cfg[REG_EXP_CTRL];
              default: b = 8'($urandom_range(0, 255));
            endcase
            push_line(($urandom_range(0, 15) == 0) ? KIND_RESTART : KIND_BYTE, b);
          end
        end
        2: queue_frame(FR_DUP, 0, 1'($urandom_range(0, 1)));
        3: queue_frame(FR_BAD_TRAILER, n, $urandom_range(0, 3) != 0);
        4: queue_frame(FR_BAD_HEADER, n, $urandom_range(0, 3) != 0);
        5: queue_frame(FR_GOOD, 0, 1'b1);
        default: queue_frame(FR_GOOD, n, $urandom_range(0, 4) != 0);
      endcase
    end
  endtask

  // Register write with setup and access cycles, then read it back.
  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg[idx] = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != {24'd0, val}) report_mismatch("register readback", prdata, {24'd0, val});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] fl, input logic [7:0] es, input logic [7:0] ef,
                           input logic [7:0] ee, input logic [7:0] ad, input logic [7:0] ec,
                           input logic [7:0] dc);
    cfg_write(REG_FLAG, fl);
    cfg_write(REG_ESCAPE, es);
    cfg_write(REG_ESC_FLAG, ef);
    cfg_write(REG_ESC_ESC, ee);
    cfg_write(REG_ADDRESS, ad);
    cfg_write(REG_EXP_CTRL, ec);
    cfg_write(REG_DUP_CTRL, dc);
  endtask

  // Wait until everything queued has been accepted and every result has come back.
  task automatic wait_idle;
    while (line_q.size() != 0 || s_axis_tvalid || frame_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [8:0] directed [0:24];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under reset register values: escaped flag, escaped escape and an
    // unknown escape in a good frame, a byte in the sticky stop state, a duplicate,
    // a restart carrying a nonzero byte, and a frame closed with no payload at all.
    directed = '{{KIND_RESTART, 8'hFF}, 9'h07E, 9'h003, 9'h000, 9'h003,
                 9'h07D, 9'h05E, 9'h07D, 9'h05D, 9'h07D, 9'h011, 9'h0FF, 9'h000,
                 9'h0FC, 9'h07E, 9'h055,
                 {KIND_RESTART, 8'h00}, 9'h07E, 9'h003, 9'h040,
                 9'h07E, 9'h003, 9'h000, 9'h003, 9'h07E};
    foreach (directed[i]) push_line(directed[i][8], directed[i][7:0]);

    queue_random(RANDOM_ITEMS);
    queue_random(RANDOM_ITEMS / 2);
    // Start the long receiver hold-off while the sender still has plenty queued.
    hold_armed <= 1'b1;
    wait_idle();

    // Extremes of every register.
    write_all(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
    queue_random(RANDOM_ITEMS);
    wait_idle();

    write_all(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    queue_random(RANDOM_ITEMS / 2);
    wait_idle();

    // Random register values.
    write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    queue_random(RANDOM_ITEMS);
    wait_idle();

    // Overlapping codes: escape equals flag, both escape codes equal, expected equals duplicate.
    write_all(8'h7E, 8'h7E, 8'h5E, 8'h5E, 8'h81, 8'h11, 8'h11);
    queue_random(RANDOM_ITEMS / 2);
    wait_idle();

    // Back to the usual values.
    write_all(8'd126, 8'd125, 8'd94, 8'd93, 8'd3, 8'd0, 8'd64);
    queue_random(RANDOM_ITEMS);
    wait_idle();

    if (err_count == 0) begin
      $display("hdlc_style_frame_receiver_test OK");
    end else begin
      $display("hdlc_style_frame_receiver_test NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("hdlc_style_frame_receiver_test NOT OK");
    $finish;
  end

endmodule
